// File: hw/rtl/dfc_pkg.sv
package dfc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TAPS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int TAP_IDX_W  = 6;
  localparam int TAPS_CFG_W = 7;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 7'd64;

  // Accumulator holds [-2^62, 2^62-1]; the running sum needs one more bit
  localparam int ACC_W = 63;
  localparam int SUM_W = 64;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;      // zero one entry of both memories
    logic coef_wr;  // write one coefficient from the input item
    logic start;    // take a sample, clear the accumulator
    logic issue;    // read one tap pair into the MAC pipeline
    logic finish;   // round, saturate and load the output register
  } dfc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // clearing pass at its last entry
    logic taps_zero;   // no active taps configured
    logic last_issue;  // current tap is the last one
    logic drained;     // no read in flight; last product lands this cycle
    logic out_free;    // output register can take a result
  } dfc_sts_t;

endpackage

// File: hw/rtl/dfc_ifs.sv
// Input channel: one item is a sample or a coefficient load
interface dfc_in_if #(
  parameter int SAMPLE_WIDTH = dfc_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [SAMPLE_WIDTH-1:0]      sample_value;
  logic        [dfc_pkg::TAP_IDX_W-1:0] tap_index;
  logic signed [SAMPLE_WIDTH-1:0]      coefficient_value;

  modport source (
    output valid, kind, sample_value, tap_index, coefficient_value,
    input  ready
  );
  modport sink (
    input  valid, kind, sample_value, tap_index, coefficient_value,
    output ready
  );
endinterface

// Result channel: one filtered sample per sample item
interface dfc_out_if #(
  parameter int SAMPLE_WIDTH = dfc_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_sample;

  modport source (
    output valid, filtered_sample,
    input  ready
  );
  modport sink (
    input  valid, filtered_sample,
    output ready
  );
endinterface

// File: hw/rtl/direct_fir_convolver.sv
// Sample item: N = min(active_taps, MAX_TAPS) >= 1 taps are summed, and no new item is taken
//   until the result is loaded into the output register; the load waits while that is full.
//   With no active taps the MAC is skipped and the result is zero.
//   One shared multiply-accumulate walks the taps, one per cycle, through a pipelined read and multiply.
// Coefficient item: no result; the block stays ready, so the next item follows at once.
// Reset: synchronous, active low; then a clearing pass zeroes both memories entry by entry, input not ready.
module direct_fir_convolver #(
  parameter int MAX_TAPS     = dfc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = dfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  dfc_in_if.sink                                in_if,
  dfc_out_if.source                             out_if,
  input  logic                                  cfg_we,
  input  logic [dfc_pkg::TAPS_CFG_W-1:0]        cfg_wdata
);

  dfc_pkg::dfc_cmd_t cmd;
  dfc_pkg::dfc_sts_t sts;

  // Sequencer
  dfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_kind  (in_if.kind),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories, MAC and output register
  dfc_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .sample_value      (in_if.sample_value),
    .tap_index         (in_if.tap_index),
    .coefficient_value (in_if.coefficient_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_data          (out_if.filtered_sample)
  );

endmodule

// File: hw/rtl/dfc_ctrl.sv
module dfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  dfc_pkg::dfc_sts_t sts,
  output dfc_pkg::dfc_cmd_t cmd
);

  dfc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfc_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      dfc_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = dfc_pkg::S_IDLE;
        end
      end
      dfc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == dfc_pkg::KIND_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.taps_zero ? dfc_pkg::S_DONE : dfc_pkg::S_RUN;
          end
        end
      end
      dfc_pkg::S_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = dfc_pkg::S_DRAIN;
        end
      end
      dfc_pkg::S_DRAIN: begin
        if (sts.drained) begin
          state_nxt = dfc_pkg::S_DONE;
        end
      end
      dfc_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dfc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dfc_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/dfc_datapath.sv
module dfc_datapath #(
  parameter int MAX_TAPS     = dfc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = dfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dfc_pkg::dfc_cmd_t                    cmd,
  output dfc_pkg::dfc_sts_t                    sts,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_value,
  input  logic        [dfc_pkg::TAP_IDX_W-1:0] tap_index,
  input  logic signed [SAMPLE_WIDTH-1:0]       coefficient_value,
  input  logic                                 cfg_we,
  input  logic        [dfc_pkg::TAPS_CFG_W-1:0] cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_data
);

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int FRAC   = SAMPLE_WIDTH - 1;
  localparam int SUM_W  = dfc_pkg::SUM_W;
  localparam int ACC_W  = dfc_pkg::ACC_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(1) <<< (FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< FRAC) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Memories
  logic signed [SAMPLE_WIDTH-1:0] dly_mem  [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];

  // Pointers and counters
  logic [AW-1:0] wp_r, rp_r, k_r, taps_m1_r;
  logic [dfc_pkg::TAPS_CFG_W-1:0] taps_r;

  // MAC pipeline
  logic                           rd_v_r, mul_v_r;
  logic signed [SAMPLE_WIDTH-1:0] coef_q_r, smp_q_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        acc_r;

  // Output register
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;

  logic [31:0]             tap_ext;
  logic [31:0]             taps_lim;
  logic                    coef_we;
  logic signed [SUM_W-1:0] sum, sum_clamp, rsum, shifted, sat_val;

  // Coefficient write address and range check
  assign tap_ext = 32'(tap_index);
  assign coef_we = cmd.coef_wr && (tap_ext < 32'(MAX_TAPS));

  // Active taps limited to the store depth
  assign taps_lim = (32'(taps_r) > 32'(MAX_TAPS)) ? 32'(MAX_TAPS) : 32'(taps_r);

  // Status
  assign sts.clr_last   = (k_r == LAST_ADDR);
  assign sts.taps_zero  = (taps_r == '0);
  assign sts.last_issue = (k_r == taps_m1_r);
  assign sts.drained    = !rd_v_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= dfc_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      taps_r <= cfg_wdata;
    end
  end

  // Tap counter and write position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      wp_r <= '0;
    end else begin
      if (cmd.clr || cmd.issue) begin
        k_r <= k_r + AW'(1);
      end else if (cmd.start) begin
        k_r <= '0;
      end
      if (cmd.start) begin
        wp_r <= (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rp_r      <= wp_r;
      taps_m1_r <= AW'(taps_lim - 32'd1);
    end else if (cmd.issue) begin
      rp_r <= (rp_r == '0) ? LAST_ADDR : rp_r - AW'(1);
    end
  end

  // Delay line: clear, write the new sample, read one tap back
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      dly_mem[k_r] <= '0;
    end else if (cmd.start) begin
      dly_mem[wp_r] <= sample_value;
    end
    if (cmd.issue) begin
      smp_q_r <= dly_mem[rp_r];
    end
  end

  // Coefficient store: clear, load one tap, read tap k
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      coef_mem[k_r] <= '0;
    end else if (coef_we) begin
      coef_mem[tap_ext[AW-1:0]] <= coefficient_value;
    end
    if (cmd.issue) begin
      coef_q_r <= coef_mem[k_r];
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
    end
  end

  // Multiply
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= coef_q_r * smp_q_r;
    end
  end

  // Accumulate with clamping to the accumulator range
  always_comb begin
    sum       = SUM_W'(acc_r) + SUM_W'(prod_r);
    sum_clamp = sum;
    if (sum > ACC_HI) begin
      sum_clamp = ACC_HI;
    end else if (sum < ACC_LO) begin
      sum_clamp = ACC_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= ACC_W'(sum_clamp);
    end
  end

  // Round half up to the sample format, then saturate
  always_comb begin
    rsum    = SUM_W'(acc_r) + RND;
    shifted = rsum >>> FRAC;
    sat_val = shifted;
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI;
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= sat_val[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/dfc_checker.sv
module dfc_checker #(
  parameter int SAMPLE_WIDTH = dfc_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_kind,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_data
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A result leaves only when taken
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without a handshake");

  // A sample item occupies the block: no item in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == dfc_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("item accepted during a filter pass");

  // A coefficient load leaves the block ready
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == dfc_pkg::KIND_COEF) |=> in_ready)
    else $error("coefficient load stalled the input");

endmodule

bind direct_fir_convolver dfc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_kind   (in_if.kind),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.filtered_sample)
);
